// ----- rtl/core/planar_pose_compose_macros.svh -----
// Assertion helpers shared by the pose composition RTL.
// Each macro expects clk and arst_n to exist in the module that uses it.
`ifndef PLANAR_POSE_COMPOSE_MACROS_SVH
`define PLANAR_POSE_COMPOSE_MACROS_SVH

`ifndef SYNTHESIS

`define PPC_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define PPC_ASSERT_DELAY(name, ante, n, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##(n) (cons)) \
		else $error(msg);

`else

`define PPC_ASSERT_IMPL(name, ante, cons, msg)

`define PPC_ASSERT_DELAY(name, ante, n, cons, msg)

`endif

`endif

// ----- rtl/core/ppc_pkg.sv -----
`default_nettype none

package ppc_pkg;

	localparam int ANG_BITS = 30;
	localparam int CW = 34;
	localparam int TABLE_LEN = 24;

	localparam logic OP_COMPOSE = 1'b0;
	localparam logic OP_INVERSE = 1'b1;

	localparam logic signed [33:0] TWO_PI_Q30 = 34'sd6746518852;
	localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [33:0] TWO_PI_LESS_HALF = TWO_PI_Q30 - HALF_PI_Q30;
	localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
	localparam logic signed [CW-1:0] UNIT_Q30 = 34'sd1073741824;

	localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

	localparam logic [29:0] ATAN_Q30 [TABLE_LEN] = '{
		30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
		30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
		30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
		30'd262143,    30'd131071,    30'd65535,     30'd32767,
		30'd16383,     30'd8191,      30'd4095,      30'd2047,
		30'd1023,      30'd511,       30'd255,       30'd127
	};

	typedef struct packed {
		logic               opcode;
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_heading;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_heading;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] c_x;
		logic signed [31:0] c_y;
		logic signed [31:0] c_heading;
		logic               overflow;
	} res_t;

	typedef struct packed {
		logic               vld;
		logic               neg;
		logic signed [31:0] z;
	} ang_t;

	typedef struct packed {
		logic                 vld;
		logic                 neg;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
	} trig_t;

	typedef struct packed {
		logic               op;
		logic signed [32:0] u;
		logic signed [32:0] v;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [32:0] head;
	} side_t;

	// Residue modulo 2*pi (Q30) of one heading byte at its place in the word.
	// The top byte carries the sign of the heading.
	// The residue is built by doubling and reducing once per bit of shift.
	function automatic logic [32:0] red_entry(input int j, input int v, input int k);
		longint m;
		bit     negv;
		negv = (j == 3 && v >= 128);
		if (negv) begin
			m = longint'(256 - v);
		end else begin
			m = longint'(v);
		end
		for (int i = 0; i < 8 * j + k; i++) begin
			m = m + m;
			if (m >= longint'(TWO_PI_Q30)) begin
				m = m - longint'(TWO_PI_Q30);
			end
		end
		if (negv && m != 0) begin
			m = longint'(TWO_PI_Q30) - m;
		end
		return m[32:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ppc_angle_reduce.sv -----
`default_nettype none

`include "planar_pose_compose_macros.svh"

module ppc_angle_reduce #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld,
	input  logic signed [31:0] heading,
	output ppc_pkg::ang_t      ang
);
	import ppc_pkg::*;

	localparam int KSHIFT = ANG_BITS - FRAC_BITS;

	logic [32:0] tab [4][256];

	for (genvar gj = 0; gj < 4; gj++) begin : g_tab
		for (genvar gv = 0; gv < 256; gv++) begin : g_ent
			localparam logic [32:0] ENTRY = red_entry(gj, gv, KSHIFT);
			assign tab[gj][gv] = ENTRY;
		end
	end

	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	logic [32:0]        t_s1 [4];
	logic [32:0]        q0_s2, q1_s2;
	logic [32:0]        r_s3;
	logic signed [31:0] z_s4;
	logic               neg_s4;

	logic [33:0] p0, p1, p2, rr, zz;
	logic        nn;

	always_comb begin
		p0 = 34'(t_s1[0]) + 34'(t_s1[1]);
		p1 = 34'(t_s1[2]) + 34'(t_s1[3]);
		p2 = 34'(q0_s2) + 34'(q1_s2);
		rr = 34'(r_s3);
		nn = 1'b0;
		if (rr <= HALF_PI_Q30) begin
			zz = rr;
		end else if (rr < TWO_PI_LESS_HALF) begin
			zz = rr - PI_Q30;
			nn = 1'b1;
		end else begin
			zz = rr - TWO_PI_Q30;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 4; j++) begin
			t_s1[j] <= tab[j][heading[8*j +: 8]];
		end
		q0_s2 <= (p0 >= TWO_PI_Q30) ? 33'(p0 - TWO_PI_Q30) : p0[32:0];
		q1_s2 <= (p1 >= TWO_PI_Q30) ? 33'(p1 - TWO_PI_Q30) : p1[32:0];
		r_s3 <= (p2 >= TWO_PI_Q30) ? 33'(p2 - TWO_PI_Q30) : p2[32:0];
		z_s4 <= $signed(zz[31:0]);
		neg_s4 <= nn;
	end

	assign ang.vld = vld_s4;
	assign ang.neg = neg_s4;
	assign ang.z = z_s4;

	`PPC_ASSERT_IMPL(a_residue_range, vld_s3, 34'(r_s3) < TWO_PI_Q30, "residue not below 2*pi")
	`PPC_ASSERT_IMPL(a_fold_range, vld_s4, (34'(z_s4) <= HALF_PI_Q30) && (34'(z_s4) >= -HALF_PI_Q30), "folded angle outside half pi")

endmodule

`default_nettype wire

// ----- rtl/core/ppc_cordic.sv -----
`default_nettype none

`include "planar_pose_compose_macros.svh"

module ppc_cordic #(
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ppc_pkg::ang_t  ang,
	output ppc_pkg::trig_t trig
);
	import ppc_pkg::*;

	localparam int N = TRIG_ITERATIONS;

	logic                 vld_s [N];
	logic                 neg_s [N];
	logic signed [CW-1:0] x_s [N];
	logic signed [CW-1:0] y_s [N];
	logic signed [CW-1:0] z_s [N];

	logic                 vin [N];
	logic                 nin [N];
	logic signed [CW-1:0] xin [N];
	logic signed [CW-1:0] yin [N];
	logic signed [CW-1:0] zin [N];
	logic signed [CW-1:0] xnx [N];
	logic signed [CW-1:0] ynx [N];
	logic signed [CW-1:0] znx [N];

	assign vin[0] = ang.vld;
	assign nin[0] = ang.neg;
	assign xin[0] = GAIN_Q30;
	assign yin[0] = '0;
	assign zin[0] = CW'(ang.z);

	for (genvar gi = 1; gi < N; gi++) begin : g_link
		assign vin[gi] = vld_s[gi-1];
		assign nin[gi] = neg_s[gi-1];
		assign xin[gi] = x_s[gi-1];
		assign yin[gi] = y_s[gi-1];
		assign zin[gi] = z_s[gi-1];
	end

	always_comb begin
		for (int i = 0; i < N; i++) begin
			if (zin[i] >= 0) begin
				xnx[i] = xin[i] - (yin[i] >>> i);
				ynx[i] = yin[i] + (xin[i] >>> i);
				znx[i] = zin[i] - $signed(CW'(ATAN_Q30[i]));
			end else begin
				xnx[i] = xin[i] + (yin[i] >>> i);
				ynx[i] = yin[i] - (xin[i] >>> i);
				znx[i] = zin[i] + $signed(CW'(ATAN_Q30[i]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else begin
			for (int i = 0; i < N; i++) begin
				vld_s[i] <= vin[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < N; i++) begin
			neg_s[i] <= nin[i];
			x_s[i] <= xnx[i];
			y_s[i] <= ynx[i];
			z_s[i] <= znx[i];
		end
	end

	assign trig.vld = vld_s[N-1];
	assign trig.neg = neg_s[N-1];
	assign trig.x = x_s[N-1];
	assign trig.y = y_s[N-1];

	`PPC_ASSERT_DELAY(a_iter_chain, ang.vld, N, trig.vld, "rotation chain lost a transfer")

endmodule

`default_nettype wire

// ----- rtl/core/ppc_rotate.sv -----
`default_nettype none

module ppc_rotate (
	input  logic           clk,
	input  logic           arst_n,
	input  ppc_pkg::trig_t trig,
	input  ppc_pkg::side_t side,
	output logic           done,
	output ppc_pkg::res_t  res
);
	import ppc_pkg::*;

	localparam int PW = 65;
	localparam int AW = 66;
	localparam int RW = AW - ANG_BITS;
	localparam int SW = 38;
	localparam logic signed [AW-1:0] RND = 66'sd536870912;
	localparam logic signed [SW-1:0] LIM_HI = 38'sd2147483647;
	localparam logic signed [SW-1:0] LIM_LO = -38'sd2147483648;

	function automatic logic signed [31:0] clamp_unit(input logic signed [CW-1:0] v);
		if (v > UNIT_Q30) begin
			return 32'sd1073741824;
		end else if (v < -UNIT_Q30) begin
			return -32'sd1073741824;
		end
		return $signed(v[31:0]);
	endfunction

	function automatic logic [32:0] sat32(input logic signed [SW-1:0] v);
		if (v > LIM_HI) begin
			return {1'b1, SAT_MAX};
		end else if (v < LIM_LO) begin
			return {1'b1, SAT_MIN};
		end
		return {1'b0, v[31:0]};
	endfunction

	logic vld_s1, vld_s2, vld_s3, vld_s4;

	logic signed [31:0] c_s1, s_s1;
	side_t              side_s1, side_s2, side_s3;
	logic signed [PW-1:0] puc_s2, pvs_s2, pus_s2, pvc_s2;
	logic signed [RW-1:0] rx_s3, ry_s3;
	res_t               res_s4;

	logic signed [CW-1:0] xn, yn;
	logic signed [AW-1:0] acc_x, acc_y;
	logic signed [SW-1:0] fx, fy;
	logic [32:0]          sx, sy, sh;

	always_comb begin
		xn = trig.neg ? -trig.x : trig.x;
		yn = (trig.neg ^ (side.op == OP_INVERSE)) ? -trig.y : trig.y;
		acc_x = AW'(puc_s2) - AW'(pvs_s2) + RND;
		acc_y = AW'(pus_s2) + AW'(pvc_s2) + RND;
		fx = SW'(rx_s3) + ((side_s3.op == OP_COMPOSE) ? SW'(side_s3.b_x) : 38'sd0);
		fy = SW'(ry_s3) + ((side_s3.op == OP_COMPOSE) ? SW'(side_s3.b_y) : 38'sd0);
		sx = sat32(fx);
		sy = sat32(fy);
		sh = sat32(SW'(side_s3.head));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= trig.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		c_s1 <= clamp_unit(xn);
		s_s1 <= clamp_unit(yn);
		side_s1 <= side;

		puc_s2 <= PW'(side_s1.u) * PW'(c_s1);
		pvs_s2 <= PW'(side_s1.v) * PW'(s_s1);
		pus_s2 <= PW'(side_s1.u) * PW'(s_s1);
		pvc_s2 <= PW'(side_s1.v) * PW'(c_s1);
		side_s2 <= side_s1;

		rx_s3 <= acc_x[AW-1:ANG_BITS];
		ry_s3 <= acc_y[AW-1:ANG_BITS];
		side_s3 <= side_s2;

		res_s4.c_x <= $signed(sx[31:0]);
		res_s4.c_y <= $signed(sy[31:0]);
		res_s4.c_heading <= $signed(sh[31:0]);
		res_s4.overflow <= sx[32] | sy[32] | sh[32];
	end

	assign done = vld_s4;
	assign res = res_s4;

endmodule

`default_nettype wire

// ----- rtl/core/planar_pose_compose.sv -----
// Planar pose composition engine, Q16.16 fixed point.
// A command transfer happens on a rising edge with start high and busy low;
// busy is always low, so a new command may be issued in every cycle.
// cmd carries the opcode and two poses a and b. Opcode compose maps local
// pose a into the frame of b; opcode inverse expresses global pose a in
// the frame of b. The heading of b is reduced modulo 2*pi through byte
// residue tables in a registered pipeline, then sine and cosine come from a
// CORDIC chain with one register stage per iteration, followed by registered
// stages that clamp sine and cosine, multiply, round and saturate. The
// throughput is one transfer per clock, set by the fully pipelined chain.
// Each result is shown on res for exactly one cycle with done high, and
// the receiver must take it then; it cannot hold results off.
// Every result field saturates to the signed 32-bit range, and overflow
// reports that at least one field did.
// Reset clears all valid bits; commands in flight are dropped and no
// result appears until a new command is transferred after reset.
`default_nettype none

`include "planar_pose_compose_macros.svh"

module planar_pose_compose #(
	parameter int FRAC_BITS = 16,
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ppc_pkg::cmd_t cmd,
	output logic          done,
	output ppc_pkg::res_t res
);
	import ppc_pkg::*;

	localparam int DLY = 4 + TRIG_ITERATIONS;
	localparam int LAT = DLY + 4;

	logic  take;
	ang_t  ang;
	trig_t trig;
	side_t side_in;
	side_t side_s [DLY];

	logic signed [32:0] dx, dy;

	assign busy = 1'b0;
	assign take = start && !busy;

	always_comb begin
		dx = 33'(cmd.a_x) - 33'(cmd.b_x);
		dy = 33'(cmd.a_y) - 33'(cmd.b_y);
		side_in.op = cmd.opcode;
		side_in.b_x = cmd.b_x;
		side_in.b_y = cmd.b_y;
		if (cmd.opcode == OP_INVERSE) begin
			side_in.u = dx;
			side_in.v = dy;
			side_in.head = 33'(cmd.a_heading) - 33'(cmd.b_heading);
		end else begin
			side_in.u = 33'(cmd.a_x);
			side_in.v = 33'(cmd.a_y);
			side_in.head = 33'(cmd.a_heading) + 33'(cmd.b_heading);
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= side_in;
		for (int i = 1; i < DLY; i++) begin
			side_s[i] <= side_s[i-1];
		end
	end

	ppc_angle_reduce #(
		.FRAC_BITS(FRAC_BITS)
	) u_angle (
		.clk(clk),
		.arst_n(arst_n),
		.vld(take),
		.heading(cmd.b_heading),
		.ang(ang)
	);

	ppc_cordic #(
		.TRIG_ITERATIONS(TRIG_ITERATIONS)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.ang(ang),
		.trig(trig)
	);

	ppc_rotate u_rotate (
		.clk(clk),
		.arst_n(arst_n),
		.trig(trig),
		.side(side_s[DLY-1]),
		.done(done),
		.res(res)
	);

	`PPC_ASSERT_DELAY(a_latency, take, LAT, done, "command transfer produced no result")
	`PPC_ASSERT_IMPL(a_ovf_sat, done && res.overflow, (res.c_x == SAT_MAX) || (res.c_x == SAT_MIN) || (res.c_y == SAT_MAX) || (res.c_y == SAT_MIN) || (res.c_heading == SAT_MAX) || (res.c_heading == SAT_MIN), "overflow without a saturated field")

endmodule

`default_nettype wire
